>>> rtl/sgdm_pkg.sv
`timescale 1ns / 1ps
package sgdm_pkg;

	// Field and register widths
	localparam int IDX_W       = 10;
	localparam int DATA_W      = 32;
	localparam int LR_W        = 25;
	localparam int MOM_W       = 24;
	localparam int DEC_W       = 25;
	localparam int ITER_W      = 32;
	localparam int DEN_W       = 58;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 25;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [LR_W-1:0] LR_RESET = 25'd167772;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_RATE = 2'd0,
		CFG_MOMENTUM  = 2'd1,
		CFG_DECAY     = 2'd2,
		CFG_NESTEROV  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LR_W-1:0]  base_rate;
		logic [MOM_W-1:0] momentum;
		logic [DEC_W-1:0] decay;
		logic             nesterov;
	} sgd_cfg_t;

	// One item after the front stage: fields plus the decayed-rate divisor
	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] grad;
		logic signed [DATA_W-1:0] param;
		logic [DEN_W-1:0]         denom;
	} work_item_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

>>> rtl/sgdm_front.sv
`timescale 1ns / 1ps
module sgdm_front #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sgdm_pkg::sgd_cfg_t                      cfg,
	input  sgdm_pkg::back_status_t                  status,
	input  logic                                    push,
	output logic                                    full,
	input  logic [sgdm_pkg::IDX_W-1:0]              element_index,
	input  logic signed [sgdm_pkg::DATA_W-1:0]      gradient,
	input  logic signed [sgdm_pkg::DATA_W-1:0]      param_value,
	input  logic [sgdm_pkg::ITER_W-1:0]             iteration,
	input  logic                                    q_ready,
	output logic                                    q_push,
	output sgdm_pkg::work_item_t                    q_item
);

	logic                                vld_s1;
	logic [sgdm_pkg::IDX_W-1:0]          idx_s1;
	logic signed [sgdm_pkg::DATA_W-1:0]  grad_s1;
	logic signed [sgdm_pkg::DATA_W-1:0]  param_s1;
	logic [sgdm_pkg::ITER_W-1:0]         iter_s1;
	logic [sgdm_pkg::DEC_W+sgdm_pkg::ITER_W-1:0] decay_prod;
	logic                                accept;

	// Hold off input while clearing or while the queue cannot take the held item
	assign full   = status.clearing || (vld_s1 && !q_ready);
	assign accept = push && !full;
	assign q_push = vld_s1 && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= element_index;
			grad_s1  <= gradient;
			param_s1 <= param_value;
			iter_s1  <= iteration;
		end
	end

	// Form divisor 1.0 + decay * iteration
	always_comb begin
		decay_prod   = cfg.decay * iter_s1;
		q_item.idx   = idx_s1;
		q_item.grad  = grad_s1;
		q_item.param = param_s1;
		q_item.denom = sgdm_pkg::DEN_W'(decay_prod)
			+ (sgdm_pkg::DEN_W'(1) << FRAC_BITS);
	end

endmodule

>>> rtl/sgdm_queue.sv
`timescale 1ns / 1ps
module sgdm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sgdm_pkg::work_item_t item_in,
	output logic                 ready,
	input  logic                 pop,
	output logic                 valid,
	output sgdm_pkg::work_item_t item_out
);

	sgdm_pkg::work_item_t              slot_q [sgdm_pkg::QUEUE_DEPTH];
	logic [sgdm_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [sgdm_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [sgdm_pkg::QPTR_W:0]         cnt_q;

	assign ready    = cnt_q < (sgdm_pkg::QPTR_W+1)'(sgdm_pkg::QUEUE_DEPTH);
	assign valid    = cnt_q != '0;
	assign item_out = slot_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sgdm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sgdm_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (sgdm_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (sgdm_pkg::QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

>>> rtl/sgdm_back.sv
`timescale 1ns / 1ps
module sgdm_back #(
	parameter int FRAC_BITS      = 24,
	parameter int VELOCITY_DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sgdm_pkg::sgd_cfg_t                 cfg,
	output sgdm_pkg::back_status_t             status,
	input  logic                               q_valid,
	input  sgdm_pkg::work_item_t               q_item,
	output logic                               q_pop,
	input  logic                               pop,
	output logic                               empty,
	output logic [sgdm_pkg::IDX_W-1:0]         out_index,
	output logic signed [sgdm_pkg::DATA_W-1:0] new_param,
	output logic                               saturated
);

	localparam int IDX_W   = sgdm_pkg::IDX_W;
	localparam int DATA_W  = sgdm_pkg::DATA_W;
	localparam int DEN_W   = sgdm_pkg::DEN_W;
	localparam int QW      = sgdm_pkg::LR_W;
	localparam int AW      = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
	localparam int RANGE_W = 18;
	localparam int NUM_W   = sgdm_pkg::LR_W + FRAC_BITS;
	localparam int CMP_W   = DEN_W + QW;
	localparam int PROD_W  = sgdm_pkg::LR_W + DATA_W + 1;
	localparam int STEP_W  = PROD_W - FRAC_BITS + 1;
	localparam int SUM_W   = STEP_W + 2;
	localparam int NEST_W  = SUM_W + 1;
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] grad;
		logic signed [DATA_W-1:0] param;
		logic [DEN_W-1:0]         denom;
		logic [NUM_W-1:0]         rem;
		logic [QW-1:0]            quo;
	} div_stage_t;

	// Round a product to one LSB, ties away from zero
	function automatic logic signed [STEP_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] rnd;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		rnd = (mag + RND_HALF) >> FRAC_BITS;
		return p[PROD_W-1] ? -STEP_W'(rnd) : STEP_W'(rnd);
	endfunction

	// Clip to the signed 32-bit range, flag in the top bit
	function automatic logic [DATA_W:0] sat32(input logic signed [NEST_W-1:0] x);
		logic [NEST_W-DATA_W:0] top;
		top = x[NEST_W-1:DATA_W-1];
		if ((&top) || !(|top)) begin
			return {1'b0, x[DATA_W-1:0]};
		end else if (x[NEST_W-1]) begin
			return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	logic adv;
	logic clr_q;
	logic [AW-1:0] clr_cnt_q;

	div_stage_t div_q [QW];
	logic       div_vld_q [QW];

	logic                        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [IDX_W-1:0]            idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic                        inside_s1, inside_s2, inside_s3;
	logic signed [DATA_W-1:0]    param_s1, param_s2, param_s3;
	logic signed [PROD_W-1:0]    prod_s1;
	logic signed [STEP_W-1:0]    step_s2, step_s3;
	logic signed [DATA_W-1:0]    vnew_s4;
	logic signed [SUM_W-1:0]     base_s4, base_s5;
	logic                        flag_s4, flag_s5;
	logic signed [PROD_W-1:0]    prod_s5;

	logic                        res_vld_q;
	logic [IDX_W-1:0]            res_idx_q;
	logic signed [DATA_W-1:0]    res_param_q;
	logic                        res_sat_q;

	logic signed [DATA_W-1:0]    vel_mem_q [VELOCITY_DEPTH];
	logic signed [DATA_W-1:0]    vel_rd_q;
	logic                        lf_vld_q;
	logic [IDX_W-1:0]            lf_idx_q;
	logic signed [DATA_W-1:0]    lf_v_q;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic signed [DATA_W-1:0]    mem_wdata;

	logic signed [DATA_W-1:0]    v_old;
	logic signed [PROD_W-1:0]    mv;
	logic signed [SUM_W-1:0]     vsum;
	logic [DATA_W:0]             vsat;
	logic signed [DATA_W-1:0]    v_new;
	logic signed [STEP_W-1:0]    mv2_rnd;
	logic signed [NEST_W-1:0]    total;
	logic [DATA_W:0]             psat;
	div_stage_t                  div_last;

	// Whole pipeline moves when the result slot is free or being taken
	assign adv            = !res_vld_q || pop;
	assign q_pop          = adv && q_valid && !clr_q;
	assign status.clearing = clr_q;
	assign empty          = !res_vld_q;
	assign out_index      = res_idx_q;
	assign new_param      = res_param_q;
	assign saturated      = res_sat_q;

	// Clear the velocity store after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(VELOCITY_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Rate divider: one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		div_stage_t        cur;
		div_stage_t        nxt;
		logic              cur_vld;
		logic [CMP_W-1:0]  shifted;
		logic              ge;

		if (k == 0) begin : g_first
			always_comb begin
				cur.idx   = q_item.idx;
				cur.grad  = q_item.grad;
				cur.param = q_item.param;
				cur.denom = q_item.denom;
				cur.rem   = NUM_W'(cfg.base_rate) << FRAC_BITS;
				cur.quo   = '0;
				cur_vld   = q_valid && !clr_q;
			end
		end else begin : g_rest
			always_comb begin
				cur     = div_q[k-1];
				cur_vld = div_vld_q[k-1];
			end
		end

		always_comb begin
			shifted = CMP_W'(cur.denom) << (QW - 1 - k);
			ge      = CMP_W'(cur.rem) >= shifted;
			nxt     = cur;
			if (ge) begin
				nxt.rem            = cur.rem - NUM_W'(shifted);
				nxt.quo[QW-1-k]    = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_q[k] <= 1'b0;
			end else if (adv) begin
				div_vld_q[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_q[k] <= nxt;
			end
		end
	end

	assign div_last = div_q[QW-1];

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= div_vld_q[QW-1];
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			res_vld_q <= vld_s5;
		end
	end

	// Velocity update: momentum * v_old - step, bypassing the last write
	always_comb begin
		if (!inside_s3) begin
			v_old = '0;
		end else if (lf_vld_q && (lf_idx_q == idx_s3)) begin
			v_old = lf_v_q;
		end else begin
			v_old = vel_rd_q;
		end
		mv    = PROD_W'($signed({1'b0, cfg.momentum})) * PROD_W'(v_old);
		vsum  = SUM_W'(qround(mv)) - SUM_W'(step_s3);
		vsat  = sat32(NEST_W'(vsum));
		v_new = vsat[DATA_W-1:0];
	end

	// Parameter update: plain adds v_new, lookahead adds momentum * v_new - step
	always_comb begin
		mv2_rnd = qround(prod_s5);
		total   = NEST_W'(base_s5) + (cfg.nesterov ? NEST_W'(mv2_rnd) : NEST_W'(0));
		psat    = sat32(total);
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1    <= div_last.idx;
			param_s1  <= div_last.param;
			inside_s1 <= RANGE_W'(div_last.idx) < RANGE_W'(VELOCITY_DEPTH);
			prod_s1   <= PROD_W'($signed({1'b0, div_last.quo})) * PROD_W'(div_last.grad);

			idx_s2    <= idx_s1;
			param_s2  <= param_s1;
			inside_s2 <= inside_s1;
			step_s2   <= qround(prod_s1);

			idx_s3    <= idx_s2;
			param_s3  <= param_s2;
			inside_s3 <= inside_s2;
			step_s3   <= step_s2;

			idx_s4    <= idx_s3;
			vnew_s4   <= v_new;
			flag_s4   <= vsat[DATA_W];
			base_s4   <= cfg.nesterov ? (SUM_W'(param_s3) - SUM_W'(step_s3))
				: SUM_W'(param_s3);

			idx_s5    <= idx_s4;
			base_s5   <= cfg.nesterov ? base_s4 : (base_s4 + SUM_W'(vnew_s4));
			flag_s5   <= flag_s4;
			prod_s5   <= PROD_W'($signed({1'b0, cfg.momentum})) * PROD_W'(vnew_s4);

			res_idx_q   <= idx_s5;
			res_param_q <= psat[DATA_W-1:0];
			res_sat_q   <= flag_s5 || psat[DATA_W];
		end
	end

	// Last stored velocity for the back-to-back same-index case
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_vld_q <= 1'b0;
		end else if (adv && vld_s3 && inside_s3) begin
			lf_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s3 && inside_s3) begin
			lf_idx_q <= idx_s3;
			lf_v_q   <= v_new;
		end
	end

	// Velocity store port
	always_comb begin
		if (clr_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv && vld_s3 && inside_s3;
			mem_waddr = AW'(idx_s3);
			mem_wdata = v_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vel_mem_q[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			vel_rd_q <= vel_mem_q[AW'(idx_s2)];
		end
	end

endmodule

>>> rtl/sgd_momentum_update.sv
`timescale 1ns / 1ps
// SGD parameter update with momentum, Nesterov lookahead and time-based rate
// decay, in signed fixed point with FRAC_BITS fractional bits. Push one element
// (index, gradient, value, iteration) per cycle while full is low; results come
// out in order, one per cycle while pop is high. On its way to the result port
// an item passes one front register, the hand-off queue, a 25-stage divider
// that forms base_rate / (1 + decay * iteration) one quotient bit per stage,
// five multiply/round/add stages and the result register. Throughput is one
// item per cycle while pop is high, including repeated indexes. After reset
// the velocity store is cleared entry by entry, during which full stays high;
// configuration writes are taken at any time but must only be issued while no
// items are in flight.
module sgd_momentum_update #(
	parameter int VELOCITY_DEPTH = 1024,
	parameter int FRAC_BITS      = 24
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	output logic                                     full,
	input  logic [sgdm_pkg::IDX_W-1:0]               element_index,
	input  logic signed [sgdm_pkg::DATA_W-1:0]       gradient,
	input  logic signed [sgdm_pkg::DATA_W-1:0]       param_value,
	input  logic [sgdm_pkg::ITER_W-1:0]              iteration,
	output logic                                     empty,
	input  logic                                     pop,
	output logic [sgdm_pkg::IDX_W-1:0]               out_index,
	output logic signed [sgdm_pkg::DATA_W-1:0]       new_param,
	output logic                                     saturated,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [sgdm_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [sgdm_pkg::CFG_DATA_W-1:0]          cfg_data
);

	sgdm_pkg::sgd_cfg_t     cfg_q;
	sgdm_pkg::back_status_t status;
	sgdm_pkg::work_item_t   fq_item;
	sgdm_pkg::work_item_t   qb_item;
	logic                   fq_push;
	logic                   fq_ready;
	logic                   qb_valid;
	logic                   qb_pop;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_rate <= sgdm_pkg::LR_RESET;
			cfg_q.momentum  <= '0;
			cfg_q.decay     <= '0;
			cfg_q.nesterov  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sgdm_pkg::cfg_reg_t'(cfg_index))
				sgdm_pkg::CFG_BASE_RATE: begin
					cfg_q.base_rate <= cfg_data[sgdm_pkg::LR_W-1:0];
				end
				sgdm_pkg::CFG_MOMENTUM: begin
					cfg_q.momentum <= cfg_data[sgdm_pkg::MOM_W-1:0];
				end
				sgdm_pkg::CFG_DECAY: begin
					cfg_q.decay <= cfg_data[sgdm_pkg::DEC_W-1:0];
				end
				sgdm_pkg::CFG_NESTEROV: begin
					cfg_q.nesterov <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	sgdm_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.status        (status),
		.push          (push),
		.full          (full),
		.element_index (element_index),
		.gradient      (gradient),
		.param_value   (param_value),
		.iteration     (iteration),
		.q_ready       (fq_ready),
		.q_push        (fq_push),
		.q_item        (fq_item)
	);

	sgdm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.item_in  (fq_item),
		.ready    (fq_ready),
		.pop      (qb_pop),
		.valid    (qb_valid),
		.item_out (qb_item)
	);

	sgdm_back #(
		.FRAC_BITS      (FRAC_BITS),
		.VELOCITY_DEPTH (VELOCITY_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.status    (status),
		.q_valid   (qb_valid),
		.q_item    (qb_item),
		.q_pop     (qb_pop),
		.pop       (pop),
		.empty     (empty),
		.out_index (out_index),
		.new_param (new_param),
		.saturated (saturated)
	);

endmodule

>>> rtl/sgdm_checker.sv
`timescale 1ns / 1ps
module sgdm_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     push,
	input logic                                     full,
	input logic                                     empty,
	input logic                                     pop,
	input logic [sgdm_pkg::IDX_W-1:0]               out_index,
	input logic signed [sgdm_pkg::DATA_W-1:0]       new_param,
	input logic                                     saturated
);

	// Front register, queue, divider stages, datapath stages, result register
	localparam int CAP = 1 + sgdm_pkg::QUEUE_DEPTH + sgdm_pkg::LR_W + 5 + 1;

	logic [7:0] pend_q;

	// Track items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(push && !full) - 8'(pop && !empty);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 8'd0) |-> empty)
		else $error("result shown with no item outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 8'(CAP))
		else $error("more items outstanding than the pipeline holds");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_index) && $stable(new_param)
			&& $stable(saturated)))
		else $error("waiting result changed before it was taken");

endmodule

bind sgd_momentum_update sgdm_checker u_sgdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_index (out_index),
	.new_param (new_param),
	.saturated (saturated)
);
